[rtl/okq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package okq_pkg;

	localparam int MAX_CLUSTERS = 12;
	localparam int IDX_W = $clog2(MAX_CLUSTERS);
	localparam int K_W = 4;
	localparam int CENTRE_W = 32;
	localparam int VOLT_W = 16;
	localparam int DIVIDEND_W = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [K_W-1:0] k_t;
	typedef logic signed [CENTRE_W-1:0] centre_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_NUM_CLUSTERS = 3'd0,
		REG_LEARN_RATE = 3'd1,
		REG_RESET_SPREAD = 3'd2,
		REG_SEMITONE_SNAP = 3'd3,
		REG_TRIGGER_GATED = 3'd4,
		REG_LEARN_ENABLE = 3'd5
	} reg_index_t;

	// Quotient and remainder of the spread step division.
	typedef struct packed {
		logic [DIVIDEND_W-1:0] quot;
		logic [K_W-1:0] rem;
	} div_result_t;

	// Request to the output formatter.
	typedef struct packed {
		logic valid;
		logic snap;
		centre_t centre;
	} fmt_req_t;

	localparam logic signed [VOLT_W-1:0] OUT_LIMIT = 16'sd20480;

endpackage

`default_nettype wire

[rtl/okq_centre_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module okq_centre_ram (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire okq_pkg::idx_t    waddr,
	input  wire okq_pkg::centre_t wdata,
	input  wire logic             re,
	input  wire okq_pkg::idx_t    raddr,
	output okq_pkg::centre_t      rdata
);

	okq_pkg::centre_t mem [okq_pkg::MAX_CLUSTERS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/okq_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

module okq_divider (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [okq_pkg::DIVIDEND_W-1:0]    dividend,
	input  wire okq_pkg::k_t                       divisor,
	output okq_pkg::div_result_t                   result,
	output logic                                   done
);

	localparam int CNT_W = $clog2(okq_pkg::DIVIDEND_W);

	logic [okq_pkg::DIVIDEND_W-1:0] quo_q;
	okq_pkg::k_t rem_q;
	okq_pkg::k_t den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [okq_pkg::K_W:0] trial;
	logic fits;
	okq_pkg::k_t rem_next;

	// One restoring step per cycle, most significant dividend bit first.
	always_comb begin
		trial = {rem_q, quo_q[okq_pkg::DIVIDEND_W-1]};
		fits = (trial >= {1'b0, den_q});
		rem_next = fits ? okq_pkg::K_W'(trial - {1'b0, den_q}) : trial[okq_pkg::K_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q <= dividend;
				rem_q <= '0;
				den_q <= divisor;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				quo_q <= {quo_q[okq_pkg::DIVIDEND_W-2:0], fits};
				rem_q <= rem_next;
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(okq_pkg::DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign result.quot = quo_q;
	assign result.rem = rem_q;
	assign done = done_q;

endmodule

`default_nettype wire

[rtl/okq_out_format.sv]
`timescale 1ns / 1ps
`default_nettype none

module okq_out_format (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire okq_pkg::fmt_req_t                req,
	output logic                                  valid,
	output logic signed [okq_pkg::VOLT_W-1:0]     quantised
);

	// Reciprocal of 12 scaled by 2^22; exact for dividends below 2^19.
	localparam logic [18:0] RECIP12 = 19'd349526;
	localparam int OUT_MAG = 20480;

	logic [31:0] mag;
	logic [32:0] rnd_sum;
	logic [35:0] m12;
	logic [35:0] n_sum;

	logic vld_s1;
	logic neg_s1;
	logic snap_s1;
	logic [16:0] rnd_s1;
	logic [8:0] n_s1;

	logic [19:0] v;
	logic [38:0] recip_prod;
	logic [16:0] mag2;
	logic [14:0] sat;

	logic vld_s2;
	logic signed [okq_pkg::VOLT_W-1:0] q_s2;

	// Both roundings work on the magnitude so that ties go away from zero.
	always_comb begin
		mag = req.centre[31] ? (~req.centre + 32'd1) : req.centre;
		rnd_sum = {1'b0, mag} + 33'd32768;
		m12 = 36'({mag, 3'b000}) + 36'({mag, 2'b00});
		n_sum = m12 + 36'd67108864;
	end

	always_comb begin
		v = 20'({n_s1, 11'b0}) + 20'd6;
		recip_prod = 39'(v) * 39'(RECIP12);
		mag2 = snap_s1 ? recip_prod[38:22] : rnd_s1;
		sat = (mag2 > 17'(OUT_MAG)) ? 15'(OUT_MAG) : mag2[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			neg_s1 <= 1'b0;
			snap_s1 <= 1'b0;
			rnd_s1 <= '0;
			n_s1 <= '0;
			vld_s2 <= 1'b0;
			q_s2 <= '0;
		end else begin
			vld_s1 <= req.valid;
			if (req.valid) begin
				neg_s1 <= req.centre[31];
				snap_s1 <= req.snap;
				rnd_s1 <= rnd_sum[32:16];
				n_s1 <= n_sum[35:27];
			end
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				q_s2 <= neg_s1 ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
			end
		end
	end

	assign valid = vld_s2;
	assign quantised = q_s2;

endmodule

`default_nettype wire

[rtl/online_kmeans_quantiser_unit.sv]
// An accepted item runs through the search (one memory read per active centre), then,
// when the centre learns, ST_MUL and ST_WRITE, then the output formatter and ST_FINISH.
// One item at a time: the next is taken only back in ST_IDLE, and later still while the
// result before is stalled. A respread (change of K or a button edge) first runs the 32
// step serial divider for the spread step, then a write sweep over the centre memory.
// After reset a spread pass fills the memory; no item is accepted until it ends.
`timescale 1ns / 1ps
`default_nettype none

module online_kmeans_quantiser_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [2:0]                       wr_index,
	input  wire logic [19:0]                      wr_data,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic signed [okq_pkg::VOLT_W-1:0] sample,
	input  wire logic signed [okq_pkg::VOLT_W-1:0] trigger_level,
	input  wire logic                             reset_button,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic signed [okq_pkg::VOLT_W-1:0]     quantised,
	output logic [3:0]                            winner_index
);

	typedef enum logic [3:0] {
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SPREAD,
		ST_IDLE,
		ST_SEARCH,
		ST_MUL,
		ST_WRITE,
		ST_FMT_GO,
		ST_FMT_WAIT,
		ST_FINISH
	} state_t;

	localparam okq_pkg::k_t RESET_K = 4'd6;
	localparam logic [14:0] RESET_SPREAD = 15'd10240;
	localparam logic signed [okq_pkg::VOLT_W-1:0] TRIG_HIGH = 16'sd2048;
	localparam logic signed [okq_pkg::VOLT_W-1:0] TRIG_LOW = 16'sd204;
	localparam okq_pkg::idx_t LAST_IDX = okq_pkg::IDX_W'(okq_pkg::MAX_CLUSTERS - 1);

	// Configuration registers.
	logic [3:0] num_clusters_q;
	logic [19:0] learn_rate_q;
	logic [14:0] reset_spread_q;
	logic semitone_snap_q;
	logic trigger_gated_q;
	logic learn_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q <= RESET_K;
			learn_rate_q <= 20'd6664;
			reset_spread_q <= RESET_SPREAD;
			semitone_snap_q <= 1'b0;
			trigger_gated_q <= 1'b0;
			learn_enable_q <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				okq_pkg::REG_NUM_CLUSTERS: num_clusters_q <= wr_data[3:0];
				okq_pkg::REG_LEARN_RATE: learn_rate_q <= wr_data;
				okq_pkg::REG_RESET_SPREAD: reset_spread_q <= wr_data[14:0];
				okq_pkg::REG_SEMITONE_SNAP: semitone_snap_q <= wr_data[0];
				okq_pkg::REG_TRIGGER_GATED: trigger_gated_q <= wr_data[0];
				okq_pkg::REG_LEARN_ENABLE: learn_enable_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	state_t state_q;
	logic init_q;
	okq_pkg::k_t prev_k_q;
	okq_pkg::k_t k_q;
	okq_pkg::k_t spr_k_q;
	logic [14:0] spr_s_q;
	logic schmitt_q;
	logic btn_q;
	logic upd_q;
	logic signed [okq_pkg::VOLT_W-1:0] sample_q;
	logic [31:0] step_q_q;
	okq_pkg::k_t step_r_q;
	logic [31:0] q_acc_q;
	okq_pkg::k_t r_acc_q;
	okq_pkg::idx_t spr_idx_q;
	okq_pkg::k_t srch_q;
	logic [32:0] best_d_q;
	okq_pkg::idx_t best_idx_q;
	okq_pkg::centre_t best_c_q;
	logic signed [53:0] prod_q;
	logic result_valid_q;
	logic signed [okq_pkg::VOLT_W-1:0] quantised_q;
	logic [3:0] winner_q;

	// Active K, respread request and trigger stage for the item on the input.
	okq_pkg::k_t k_w;
	logic respread_w;
	logic schmitt_next;
	logic fire_w;
	logic learn_w;

	always_comb begin
		if (num_clusters_q < 4'd2) begin
			k_w = 4'd2;
		end else if (num_clusters_q > okq_pkg::K_W'(okq_pkg::MAX_CLUSTERS)) begin
			k_w = okq_pkg::K_W'(okq_pkg::MAX_CLUSTERS);
		end else begin
			k_w = num_clusters_q;
		end
		respread_w = (k_w != prev_k_q) || (reset_button && !btn_q);
		schmitt_next = schmitt_q;
		fire_w = 1'b1;
		if (trigger_gated_q) begin
			fire_w = 1'b0;
			if (schmitt_q) begin
				if (trigger_level <= TRIG_LOW) begin
					schmitt_next = 1'b0;
				end
			end else if (trigger_level >= TRIG_HIGH) begin
				schmitt_next = 1'b1;
				fire_w = 1'b1;
			end
		end
		learn_w = fire_w && learn_enable_q && (learn_rate_q != 20'd0);
	end

	// Divider for the spread step 2*S / (K - 1).
	logic div_start;
	okq_pkg::div_result_t div_res;
	logic div_done;
	okq_pkg::k_t den_w;

	assign den_w = spr_k_q - 4'd1;
	assign div_start = (state_q == ST_DIV_GO);

	okq_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend({spr_s_q, 17'b0}),
		.divisor(den_w),
		.result(div_res),
		.done(div_done)
	);

	// Spread sweep arithmetic.
	logic [32:0] spread_c;
	logic [okq_pkg::K_W:0] r_sum;
	logic r_wrap;

	always_comb begin
		spread_c = {1'b0, q_acc_q} - {2'b0, spr_s_q, 16'b0};
		r_sum = {1'b0, r_acc_q} + {1'b0, step_r_q};
		r_wrap = (r_sum >= {1'b0, den_w});
	end

	// Search distance and learning arithmetic.
	logic signed [31:0] x_w;
	okq_pkg::centre_t rd_data;
	logic signed [32:0] diff_s;
	logic [32:0] dist_w;
	okq_pkg::idx_t cmp_idx;
	logic signed [32:0] diff_best;
	logic signed [53:0] prod_w;
	logic [53:0] pmag;
	logic [53:0] pround;
	logic signed [33:0] delta_mag;
	logic signed [33:0] delta;
	logic signed [33:0] newc_wide;
	okq_pkg::centre_t newc;

	always_comb begin
		x_w = {sample_q, 16'b0};
		diff_s = {x_w[31], x_w} - {rd_data[31], rd_data};
		dist_w = diff_s[32] ? 33'(-diff_s) : 33'(diff_s);
		cmp_idx = okq_pkg::IDX_W'(srch_q - 4'd1);
		diff_best = {x_w[31], x_w} - {best_c_q[31], best_c_q};
		prod_w = diff_best * $signed({1'b0, learn_rate_q});
		pmag = prod_q[53] ? 54'(-prod_q) : 54'(prod_q);
		pround = pmag + 54'd8388608;
		delta_mag = $signed({4'b0, pround[53:24]});
		delta = prod_q[53] ? -delta_mag : delta_mag;
		newc_wide = {{2{best_c_q[31]}}, best_c_q} + delta;
		if (newc_wide > 34'sd2147483647) begin
			newc = 32'sh7FFFFFFF;
		end else if (newc_wide < -34'sd2147483648) begin
			newc = 32'sh80000000;
		end else begin
			newc = newc_wide[31:0];
		end
	end

	// Centre memory ports.
	logic ram_we;
	okq_pkg::idx_t ram_waddr;
	okq_pkg::centre_t ram_wdata;
	logic ram_re;
	okq_pkg::idx_t ram_raddr;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = spr_idx_q;
		ram_wdata = '0;
		if (state_q == ST_SPREAD) begin
			ram_we = 1'b1;
			ram_wdata = ({1'b0, spr_idx_q} < {1'b0, spr_k_q}) ? spread_c[31:0] : '0;
		end else if (state_q == ST_WRITE) begin
			ram_we = 1'b1;
			ram_waddr = best_idx_q;
			ram_wdata = newc;
		end
		ram_re = (state_q == ST_SEARCH) && (srch_q < k_q);
		ram_raddr = okq_pkg::IDX_W'(srch_q);
	end

	okq_centre_ram u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// Output rounding, snap and saturation.
	okq_pkg::fmt_req_t fmt_req;
	logic fmt_valid;
	logic signed [okq_pkg::VOLT_W-1:0] fmt_q;

	always_comb begin
		fmt_req.valid = (state_q == ST_FMT_GO);
		fmt_req.snap = semitone_snap_q;
		fmt_req.centre = best_c_q;
	end

	okq_out_format u_fmt (
		.clk(clk),
		.arst_n(arst_n),
		.req(fmt_req),
		.valid(fmt_valid),
		.quantised(fmt_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DIV_GO;
			init_q <= 1'b1;
			prev_k_q <= RESET_K;
			k_q <= RESET_K;
			spr_k_q <= RESET_K;
			spr_s_q <= RESET_SPREAD;
			schmitt_q <= 1'b0;
			btn_q <= 1'b0;
			upd_q <= 1'b0;
			sample_q <= '0;
			step_q_q <= '0;
			step_r_q <= '0;
			q_acc_q <= '0;
			r_acc_q <= '0;
			spr_idx_q <= '0;
			srch_q <= '0;
			best_d_q <= '0;
			best_idx_q <= '0;
			best_c_q <= '0;
			prod_q <= '0;
			result_valid_q <= 1'b0;
			quantised_q <= '0;
			winner_q <= '0;
		end else begin
			if (result_valid_q && !result_stall && (state_q != ST_FINISH)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						step_q_q <= div_res.quot;
						step_r_q <= div_res.rem;
						q_acc_q <= '0;
						r_acc_q <= den_w >> 1;
						spr_idx_q <= '0;
						state_q <= ST_SPREAD;
					end
				end
				ST_SPREAD: begin
					// Running quotient and remainder of 2*S*i/(K-1), rounded.
					if (r_wrap) begin
						r_acc_q <= okq_pkg::K_W'(r_sum - {1'b0, den_w});
						q_acc_q <= q_acc_q + step_q_q + 32'd1;
					end else begin
						r_acc_q <= r_sum[okq_pkg::K_W-1:0];
						q_acc_q <= q_acc_q + step_q_q;
					end
					spr_idx_q <= spr_idx_q + okq_pkg::IDX_W'(1);
					if (spr_idx_q == LAST_IDX) begin
						init_q <= 1'b0;
						srch_q <= '0;
						state_q <= init_q ? ST_IDLE : ST_SEARCH;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						sample_q <= sample;
						k_q <= k_w;
						prev_k_q <= k_w;
						spr_k_q <= k_w;
						spr_s_q <= reset_spread_q;
						btn_q <= reset_button;
						schmitt_q <= schmitt_next;
						upd_q <= learn_w;
						srch_q <= '0;
						state_q <= respread_w ? ST_DIV_GO : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// Read data is registered, so it arrives in the cycle after its address.
					if (srch_q != 4'd0) begin
						if ((srch_q == 4'd1) || (dist_w < best_d_q)) begin
							best_d_q <= dist_w;
							best_idx_q <= cmp_idx;
							best_c_q <= rd_data;
						end
					end
					srch_q <= srch_q + 4'd1;
					if (srch_q == k_q) begin
						state_q <= upd_q ? ST_MUL : ST_FMT_GO;
					end
				end
				ST_MUL: begin
					prod_q <= prod_w;
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					best_c_q <= newc;
					state_q <= ST_FMT_GO;
				end
				ST_FMT_GO: begin
					state_q <= ST_FMT_WAIT;
				end
				ST_FMT_WAIT: begin
					if (fmt_valid) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						quantised_q <= fmt_q;
						winner_q <= 4'(best_idx_q);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign quantised = quantised_q;
	assign winner_index = winner_q;

`ifndef SYNTHESIS
	a_winner_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (winner_index < k_q))
		else $error("winner index beyond the active centre count");

	a_output_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((quantised <= okq_pkg::OUT_LIMIT) && (quantised >= -okq_pkg::OUT_LIMIT)))
		else $error("quantised output outside the saturation range");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr <= LAST_IDX))
		else $error("centre memory write beyond its depth");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> item_stall)
		else $error("input open while the search runs");
`endif

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int  LONG_HOLD     = 400;
	localparam int  SETTLE_CYCLES = 4;
	localparam int  TAIL_CYCLES   = 80;
	localparam int  SCHMITT_ON    = 2048;
	localparam int  SCHMITT_OFF   = 204;
	localparam int  OUT_MAX       = 20480;

	typedef struct {
		logic signed [okq_pkg::VOLT_W-1:0] quantised;
		logic [3:0]                        winner_index;
	} quant_beat_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              wr_en = 1'b0;
	logic [2:0]                        wr_index = '0;
	logic [19:0]                       wr_data = '0;
	logic                              item_valid = 1'b0;
	logic                              item_stall;
	logic signed [okq_pkg::VOLT_W-1:0] sample = '0;
	logic signed [okq_pkg::VOLT_W-1:0] trigger_level = '0;
	logic                              reset_button = 1'b0;
	logic                              result_valid;
	logic                              result_stall = 1'b0;
	logic signed [okq_pkg::VOLT_W-1:0] quantised;
	logic [3:0]                        winner_index;

	online_kmeans_quantiser_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sample(sample),
		.trigger_level(trigger_level),
		.reset_button(reset_button),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.quantised(quantised),
		.winner_index(winner_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the quantiser: registers and learned centres.
	logic [3:0]       cfg_k;
	logic [19:0]      cfg_eta;
	logic [14:0]      cfg_spread;
	logic             cfg_snap;
	logic             cfg_gated;
	logic             cfg_learn;
	okq_pkg::centre_t centre_model [okq_pkg::MAX_CLUSTERS];
	int               last_k;
	bit               schmitt_high;
	bit               button_high;

	quant_beat_t pending_codes [$];
	int          mismatch_count = 0;

	// Stimulus shaping.
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	int hold_tokens = 0;
	int hubs [4];
	bit trig_high_next = 1'b0;
	bit button_level = 1'b0;

	function automatic longint round_half_away(longint num, longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic void lay_out_centres(int k);
		longint s;
		s = longint'(cfg_spread) * 65536;
		for (int i = 0; i < okq_pkg::MAX_CLUSTERS; i++) begin
			if (i < k)
				centre_model[i] = okq_pkg::centre_t'(-s + round_half_away(2 * s * i, k - 1));
			else
				centre_model[i] = '0;
		end
	endfunction

	function automatic void reset_model();
		cfg_k = 4'd6;
		cfg_eta = 20'd6664;
		cfg_spread = 15'd10240;
		cfg_snap = 1'b0;
		cfg_gated = 1'b0;
		cfg_learn = 1'b1;
		schmitt_high = 1'b0;
		button_high = 1'b0;
		last_k = 6;
		lay_out_centres(6);
	endfunction

	function automatic quant_beat_t quantise_sample(logic signed [okq_pkg::VOLT_W-1:0] smp,
			logic signed [okq_pkg::VOLT_W-1:0] trig, logic btn);
		int          k;
		int          best;
		bit          learn_now;
		longint      x;
		longint      d_abs;
		longint      best_dist;
		longint      c;
		longint      q;
		longint      semis;
		quant_beat_t beat;
		k = int'(cfg_k);
		if (k < 2) k = 2;
		if (k > okq_pkg::MAX_CLUSTERS) k = okq_pkg::MAX_CLUSTERS;
		if (k != last_k) begin
			lay_out_centres(k);
			last_k = k;
		end
		if (btn && !button_high)
			lay_out_centres(k);
		button_high = btn;

		learn_now = 1'b1;
		if (cfg_gated) begin
			learn_now = 1'b0;
			if (schmitt_high) begin
				if (trig <= SCHMITT_OFF) schmitt_high = 1'b0;
			end else if (trig >= SCHMITT_ON) begin
				schmitt_high = 1'b1;
				learn_now = 1'b1;
			end
		end

		x = longint'(smp) * 65536;
		best = 0;
		best_dist = x - centre_model[0];
		if (best_dist < 0) best_dist = -best_dist;
		for (int i = 1; i < k; i++) begin
			d_abs = x - centre_model[i];
			if (d_abs < 0) d_abs = -d_abs;
			if (d_abs < best_dist) begin
				best_dist = d_abs;
				best = i;
			end
		end

		if (learn_now && cfg_learn && cfg_eta != 0) begin
			c = centre_model[best];
			c += round_half_away((x - c) * longint'(cfg_eta), longint'(1) << 24);
			if (c > 64'sd2147483647) c = 64'sd2147483647;
			if (c < -64'sd2147483648) c = -64'sd2147483648;
			centre_model[best] = okq_pkg::centre_t'(c);
		end

		c = centre_model[best];
		if (cfg_snap) begin
			semis = round_half_away(12 * c, longint'(1) << 27);
			q = round_half_away(semis * 2048, 12);
		end else begin
			q = round_half_away(c, 65536);
		end
		if (q > OUT_MAX) q = OUT_MAX;
		if (q < -OUT_MAX) q = -OUT_MAX;
		beat.quantised = q[okq_pkg::VOLT_W-1:0];
		beat.winner_index = best[3:0];
		return beat;
	endfunction

	// Receiver: random stalls while rx_idle is set, and a long hold-off on each request.
	int rx_left = 0;
	bit rx_level = 1'b0;
	int hold_served = 0;

	always @(posedge clk) begin
		quant_beat_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_codes.size() == 0) begin
				mismatch_count++;
				$display("%0t: result beat with nothing expected: quantised=%0d winner_index=%0d",
					$time, quantised, winner_index);
			end else begin
				want = pending_codes.pop_front();
				if (quantised !== want.quantised) begin
					mismatch_count++;
					$display("%0t: quantised mismatch: expected %0d, actual %0d",
						$time, want.quantised, quantised);
				end
				if (winner_index !== want.winner_index) begin
					mismatch_count++;
					$display("%0t: winner_index mismatch: expected %0d, actual %0d",
						$time, want.winner_index, winner_index);
				end
			end
		end

		if (rx_left == 0) begin
			if (hold_served != hold_tokens) begin
				hold_served++;
				rx_level = 1'b1;
				rx_left = LONG_HOLD;
			end else if (!rx_idle) begin
				rx_level = 1'b0;
				rx_left = 1;
			end else begin
				rx_level = ($urandom_range(0, 2) == 0);
				rx_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4)
					: $urandom_range(15, 60);
			end
		end
		rx_left--;
		result_stall <= rx_level;
	end

	function automatic int tx_gap_len();
		int roll;
		if (!tx_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offers one beat and holds it until the block takes it.
	task automatic send_item(int smp, int trig, logic btn);
		int gap;
		item_valid <= 1'b1;
		sample <= 16'(smp);
		trigger_level <= 16'(trig);
		reset_button <= btn;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pending_codes.push_back(quantise_sample(16'(smp), 16'(trig), btn));
		gap = tx_gap_len();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		item_valid <= 1'b0;
		while (pending_codes.size() != 0) @(posedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, int value);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value[19:0];
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			okq_pkg::REG_NUM_CLUSTERS:  cfg_k = value[3:0];
			okq_pkg::REG_LEARN_RATE:    cfg_eta = value[19:0];
			okq_pkg::REG_RESET_SPREAD:  cfg_spread = value[14:0];
			okq_pkg::REG_SEMITONE_SNAP: cfg_snap = value[0];
			okq_pkg::REG_TRIGGER_GATED: cfg_gated = value[0];
			okq_pkg::REG_LEARN_ENABLE:  cfg_learn = value[0];
			default: ;
		endcase
	endtask

	task automatic apply_config(int k, int eta, int spread, bit snap, bit gated, bit learn);
		set_reg(okq_pkg::REG_NUM_CLUSTERS, k);
		set_reg(okq_pkg::REG_LEARN_RATE, eta);
		set_reg(okq_pkg::REG_RESET_SPREAD, spread);
		set_reg(okq_pkg::REG_SEMITONE_SNAP, snap);
		set_reg(okq_pkg::REG_TRIGGER_GATED, gated);
		set_reg(okq_pkg::REG_LEARN_ENABLE, learn);
		for (int i = 0; i < 4; i++)
			hubs[i] = int'($urandom_range(0, 2 * spread)) - spread;
	endtask

	// Most samples land near a few hubs inside the spread so the centres settle.
	function automatic logic signed [okq_pkg::VOLT_W-1:0] pick_sample();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 16'($urandom);
		if (sel < 8)
			return 16'(hubs[$urandom_range(0, 3)] + int'($urandom_range(0, 512)) - 256);
		return 16'(int'($urandom_range(0, 40960)) - 20480);
	endfunction

	function automatic logic signed [okq_pkg::VOLT_W-1:0] pick_trigger();
		int roll;
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		if ($urandom_range(0, 2) != 0)
			trig_high_next = !trig_high_next;
		roll = $urandom_range(0, 9);
		if (trig_high_next) begin
			if (roll < 2) return 16'(SCHMITT_ON);
			if (roll < 3) return 16'(SCHMITT_ON - 1);
			return 16'($urandom_range(SCHMITT_ON + 1, 32767));
		end
		if (roll < 2) return 16'(SCHMITT_OFF);
		if (roll < 3) return 16'(SCHMITT_OFF + 1);
		return 16'(int'($urandom_range(0, 32971)) - 32768);
	endfunction

	function automatic logic pick_button();
		if ($urandom_range(0, 99) < 5)
			button_level = !button_level;
		return button_level;
	endfunction

	task automatic run_items(int count);
		for (int i = 0; i < count; i++)
			send_item(pick_sample(), pick_trigger(), pick_button());
	endtask

	// Reset layout with a sample exactly between two centres and both rails.
	task automatic test_reset_values();
		send_item(0, 0, 1'b0);
		send_item(32767, 0, 1'b0);
		send_item(-32768, 0, 1'b0);
	endtask

	// Cluster counts below two and above the maximum, learning switched off.
	task automatic test_cluster_count();
		set_reg(okq_pkg::REG_LEARN_ENABLE, 0);
		set_reg(okq_pkg::REG_NUM_CLUSTERS, 0);
		send_item(0, 0, 1'b0);
		set_reg(okq_pkg::REG_NUM_CLUSTERS, 15);
		send_item(-1, 0, 1'b0);
		send_item(1, 0, 1'b0);
		set_reg(okq_pkg::REG_NUM_CLUSTERS, 1);
		send_item(0, 0, 1'b0);
	endtask

	task automatic test_learning();
		set_reg(okq_pkg::REG_LEARN_ENABLE, 1);
		set_reg(okq_pkg::REG_LEARN_RATE, 20'hFFFFF);
		send_item(32767, 0, 1'b0);
		send_item(-32768, 0, 1'b0);
		set_reg(okq_pkg::REG_LEARN_RATE, 0);
		send_item(100, 0, 1'b0);
		set_reg(okq_pkg::REG_LEARN_RATE, 1);
		send_item(5000, 0, 1'b0);
	endtask

	// Schmitt thresholds: one code short of each, exactly on each, and the rails.
	task automatic test_trigger_gate();
		set_reg(okq_pkg::REG_LEARN_RATE, 838861);
		set_reg(okq_pkg::REG_TRIGGER_GATED, 1);
		send_item(3000, SCHMITT_ON - 1, 1'b0);
		send_item(3000, SCHMITT_ON, 1'b0);
		send_item(3000, 3000, 1'b0);
		send_item(3000, SCHMITT_OFF + 1, 1'b0);
		send_item(3000, SCHMITT_OFF, 1'b0);
		send_item(-3000, 32767, 1'b0);
		send_item(-3000, -32768, 1'b0);
	endtask

	// A wide spread pushes centres past the output limit; snap rounds to semitones.
	task automatic test_button_snap();
		set_reg(okq_pkg::REG_TRIGGER_GATED, 0);
		set_reg(okq_pkg::REG_SEMITONE_SNAP, 1);
		set_reg(okq_pkg::REG_RESET_SPREAD, 32767);
		send_item(32767, 0, 1'b1);
		send_item(1234, 0, 1'b1);
		send_item(-777, 0, 1'b0);
		send_item(-32768, 0, 1'b1);
		set_reg(okq_pkg::REG_SEMITONE_SNAP, 0);
		send_item(-32768, 0, 1'b0);
	endtask

	// Back-to-back beats while the receiver holds off, then a drain and more beats with gaps.
	task automatic test_backpressure();
		apply_config(12, 6664, 10240, 1'b0, 1'b0, 1'b1);
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		hold_tokens++;
		run_items(150);
		wait_drain();
		tx_idle = 1'b1;
		run_items(50);
	endtask

	task automatic test_random_sweep();
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: apply_config(15, 20'hFFFFF, 32767, 1'b1, 1'b0, 1'b1);
				1: apply_config(0, 0, 0, 1'b0, 1'b1, 1'b1);
				2: apply_config(12, 838861, 20480, 1'b0, 1'b1, 1'b1);
				3: apply_config(2, 1, 1024, 1'b1, 1'b0, 1'b1);
				default: apply_config($urandom_range(0, 15), $urandom_range(0, 20'hFFFFF),
					$urandom_range(0, 32767), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			endcase
			tx_idle = (p % 3 != 2);
			rx_idle = (p % 4 != 3);
			run_items(200);
		end
	endtask

	initial begin
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_cluster_count();
		test_learning();
		test_trigger_gate();
		test_button_snap();
		test_backpressure();
		test_random_sweep();
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS online_kmeans_quantiser_unit");
		else
			$display("FAIL online_kmeans_quantiser_unit");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL online_kmeans_quantiser_unit");
		$finish;
	end

endmodule

[filelist.f]
rtl/okq_pkg.sv
rtl/okq_centre_ram.sv
rtl/okq_divider.sv
rtl/okq_out_format.sv
rtl/online_kmeans_quantiser_unit.sv
tb/sv/tb.sv
